FILE: hw/rtl/loop_record_validator_macros.svh
// assertion macros for the loop record validator
`ifndef LOOP_RECORD_VALIDATOR_MACROS_SVH
`define LOOP_RECORD_VALIDATOR_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked outside reset
`define LRV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrv assertion failed");

// next-cycle implication, checked outside reset
`define LRV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrv assertion failed");

`else

`define LRV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LRV_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/lrv_pkg.sv
// types, constants and helpers for the loop record validator
package lrv_pkg;

    // fnv-1a 32-bit constants
    localparam logic [31:0] FNV_SEED  = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // item codes
    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_ENTRY  = 1'b1;

    // verdict codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_RANGE    = 2'd1;
    localparam logic [1:0] ERR_CAPACITY = 2'd2;
    localparam logic [1:0] ERR_CHECKSUM = 2'd3;

    // field widths
    localparam int WORD_W   = 32;
    localparam int TOTAL_W  = 13;
    localparam int SHIFT_W  = 8 * WORD_W;

    // index of the final byte of a header and of an entry
    localparam logic [4:0] HDR_LAST_BYTE = 5'd7;
    localparam logic [4:0] ENT_LAST_BYTE = 5'd31;

    typedef logic [31:0] t_word;

    // per-field maxima, tick first
    localparam t_word ENTRY_MAX [8] = '{
        32'd393216, 32'd393216, 32'd6, 32'd15,
        32'd127, 32'd127, 32'd16383, 32'd65535
    };

    // byte of a field maximum, least significant byte at index 0
    function automatic logic [7:0] max_byte(input logic [2:0] field, input logic [1:0] idx);
        t_word m;
        m = ENTRY_MAX[field];
        return m[{idx, 3'b000} +: 8];
    endfunction

    // one fnv-1a step over one byte
    function automatic t_word fnv_step(input t_word h, input logic [7:0] b);
        t_word x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

endpackage

FILE: hw/rtl/loop_record_validator.sv
// loop record validator: byte-serial fnv-1a checksum, range and capacity check of a loop record
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------------
//  input   | in        | i_valid / o_stall     | i_opcode .. i_layer_and_last
//  result  | out       | o_valid / i_stall     | o_accepted, o_error_code, o_computed_sum,
//          |           |                       | o_entry_total
//
//  one byte is hashed per cycle by a single multiply stage: an entry is loaded in its
//  transfer cycle and then hashes its 32 bytes, a header its 8 bytes, and an item marked
//  last then waits in the done state to move its verdict into the output register.
//  an entry with no open record is dropped in its transfer cycle.
//  reset is synchronous and active low; no clearing pass is needed.
//  a held result stalls only the done state of a last item, never the items before it.
`include "loop_record_validator_macros.svh"

module loop_record_validator
    import lrv_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input channel
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_opcode,
    input  logic [31:0]   i_loop_length,
    input  logic [15:0]   i_tempo_bpm,
    input  logic [31:0]   i_expected_sum,
    input  logic [31:0]   i_tick,
    input  logic [31:0]   i_duration,
    input  logic [31:0]   i_event_kind,
    input  logic [31:0]   i_channel,
    input  logic [31:0]   i_data_one,
    input  logic [31:0]   i_data_two,
    input  logic [31:0]   i_wide_value,
    input  logic [32:0]   i_layer_and_last,
    // result channel
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_accepted,
    output logic [1:0]    o_error_code,
    output logic [31:0]   o_computed_sum,
    output logic [12:0]   o_entry_total
);

    localparam int CNT_W = $clog2(CAPACITY + 2);
    localparam logic [CNT_W-1:0] CAP     = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_SAT = CNT_W'(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HASH = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // control state
    logic [1:0]       r_state, n_state;
    logic [4:0]       r_cnt, n_cnt;
    logic             r_is_entry, n_is_entry;
    logic             r_last, n_last;
    logic             r_gt, n_gt;
    logic             r_open, n_open;
    logic [1:0]       r_err, n_err;
    logic [CNT_W-1:0] r_entries, n_entries;
    t_word            r_hash, n_hash;
    t_word            r_expected, n_expected;
    logic             r_out_valid, n_out_valid;

    // payload
    logic [SHIFT_W-1:0] r_shift, n_shift;
    logic               r_out_acc;
    logic [1:0]         r_out_err;
    t_word              r_out_sum;
    logic [CNT_W-1:0]   r_out_total;

    logic       in_xfer;
    logic       out_free;
    logic       emit;
    logic [7:0] cur_byte;
    logic [7:0] cur_max;
    logic       cur_gt;
    logic [4:0] last_byte;
    logic [1:0] verdict;

    assign o_stall  = (r_state != ST_IDLE);
    assign in_xfer  = i_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign emit     = (r_state == ST_DONE) && out_free;

    // serial compare, least significant byte first
    assign cur_byte  = r_shift[7:0];
    assign cur_max   = max_byte(r_cnt[4:2], r_cnt[1:0]);
    assign cur_gt    = (cur_byte > cur_max)
                       || ((cur_byte == cur_max) && (r_cnt[1:0] != 2'd0) && r_gt);
    assign last_byte = r_is_entry ? ENT_LAST_BYTE : HDR_LAST_BYTE;

    // final verdict of a record
    assign verdict = ((r_err == ERR_NONE) && (r_hash != r_expected)) ? ERR_CHECKSUM : r_err;

    // next-state logic
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_is_entry  = r_is_entry;
        n_last      = r_last;
        n_gt        = r_gt;
        n_open      = r_open;
        n_err       = r_err;
        n_entries   = r_entries;
        n_hash      = r_hash;
        n_expected  = r_expected;
        n_shift     = r_shift;
        n_out_valid = r_out_valid;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_cnt  = 5'd0;
                    n_gt   = 1'b0;
                    n_last = i_layer_and_last[32];
                    if (i_opcode == OP_HEADER) begin
                        // open a fresh record
                        n_state    = ST_HASH;
                        n_is_entry = 1'b0;
                        n_open     = 1'b1;
                        n_err      = ERR_NONE;
                        n_entries  = '0;
                        n_hash     = FNV_SEED;
                        n_expected = i_expected_sum;
                        n_shift    = {192'd0, 16'd0, i_tempo_bpm, i_loop_length};
                    end else if (r_open) begin
                        // entry of an open record
                        n_state    = ST_HASH;
                        n_is_entry = 1'b1;
                        if ((r_entries >= CAP) && (r_err == ERR_NONE)) begin
                            n_err = ERR_CAPACITY;
                        end
                        if (r_entries < CAP_SAT) begin
                            n_entries = r_entries + 1'b1;
                        end
                        n_shift = {i_layer_and_last[31:0], i_wide_value, i_data_two,
                                   i_data_one, i_channel, i_event_kind, i_duration, i_tick};
                    end
                end
            end
            ST_HASH: begin
                // one byte per cycle
                n_hash  = fnv_step(r_hash, cur_byte);
                n_shift = {8'd0, r_shift[SHIFT_W-1:8]};
                n_gt    = cur_gt;
                n_cnt   = r_cnt + 1'b1;
                if (r_is_entry && (r_cnt[1:0] == 2'd3) && cur_gt && (r_err == ERR_NONE)) begin
                    n_err = ERR_RANGE;
                end
                if (r_cnt == last_byte) begin
                    n_state = r_last ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: begin
                // hand the verdict over and close the record
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    n_open      = 1'b0;
                    n_err       = ERR_NONE;
                    n_entries   = '0;
                    n_hash      = FNV_SEED;
                    n_expected  = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= 5'd0;
            r_is_entry  <= 1'b0;
            r_last      <= 1'b0;
            r_gt        <= 1'b0;
            r_open      <= 1'b0;
            r_err       <= ERR_NONE;
            r_entries   <= '0;
            r_hash      <= FNV_SEED;
            r_expected  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_is_entry  <= n_is_entry;
            r_last      <= n_last;
            r_gt        <= n_gt;
            r_open      <= n_open;
            r_err       <= n_err;
            r_entries   <= n_entries;
            r_hash      <= n_hash;
            r_expected  <= n_expected;
            r_out_valid <= n_out_valid;
        end
    end

    // byte shifter and result register
    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        if (emit) begin
            r_out_acc   <= (verdict == ERR_NONE);
            r_out_err   <= verdict;
            r_out_sum   <= r_hash;
            r_out_total <= r_entries;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_accepted     = r_out_acc;
    assign o_error_code   = r_out_err;
    assign o_computed_sum = r_out_sum;
    assign o_entry_total  = TOTAL_W'(r_out_total);

    // checks
    `LRV_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, r_state == ST_HASH, r_cnt <= last_byte)
    `LRV_ASSERT_IMP(a_entries_sat, i_clk, i_rst_n, 1'b1, r_entries <= CAP_SAT)
    `LRV_ASSERT_NXT(a_emit_result, i_clk, i_rst_n, emit,
        o_valid && (o_accepted == (o_error_code == ERR_NONE)) && !r_open)
    `LRV_ASSERT_NXT(a_orphan_drop, i_clk, i_rst_n,
        in_xfer && (i_opcode == OP_ENTRY) && !r_open, r_state == ST_IDLE)
    `LRV_ASSERT_IMP(a_done_last, i_clk, i_rst_n, r_state == ST_DONE, r_last && r_open)

endmodule

FILE: tb/loop_record_validator_test.sv
// self-checking testbench for the loop record validator: record stimulus, verdict prediction
`timescale 1ns / 1ps

module loop_record_validator_test
    import lrv_pkg::*;
();

    localparam int RECORD_CAP  = 256;
    localparam int ITEM_TARGET = 1550;
    localparam int TAIL_CYCLES = 64;
    localparam int PHASE_ITEMS = 150;

    // fnv-1a offset basis and multiplier
    localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
    localparam logic [31:0] FNV_MULT   = 32'd16777619;

    // entry field maxima, layer at index 7, tick at index 0
    localparam logic [7:0][31:0] FIELD_LIMIT = {
        32'd65535, 32'd16383, 32'd127, 32'd127, 32'd15, 32'd6, 32'd393216, 32'd393216
    };

    typedef enum int {FILL_RANDOM, FILL_LIMIT, FILL_ONES, FILL_ZERO} t_fill;

    typedef struct packed {
        logic             op;
        logic [31:0]      loop_len;
        logic [15:0]      tempo;
        logic [31:0]      stored_sum;
        logic [7:0][31:0] field;
        logic             last;
    } t_loop_item;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  code;
        logic [31:0] sum;
        logic [12:0] total;
    } t_verdict;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall;
    logic o_valid;
    logic o_accepted;
    logic [1:0] o_error_code;
    logic [31:0] o_computed_sum;
    logic [12:0] o_entry_total;

    t_loop_item cur_item = '0;
    t_loop_item pending_items[$];
    t_verdict   due_verdicts[$];
    bit         sending = 1'b0;
    int         items_taken = 0;
    int         stim_count = 0;
    int         fail_count = 0;
    int         verdicts_checked = 0;
    int         code_seen [4] = '{0, 0, 0, 0};

    // predicted block state
    logic [31:0] hash_acc  = FNV_OFFSET;
    logic [31:0] sum_want  = '0;
    logic [1:0]  err_first = ERR_NONE;
    logic [12:0] entry_cnt = '0;
    logic        rec_open  = 1'b0;

    // payload straight from the item on the bus
    wire         i_opcode         = cur_item.op;
    wire [31:0]  i_loop_length    = cur_item.loop_len;
    wire [15:0]  i_tempo_bpm      = cur_item.tempo;
    wire [31:0]  i_expected_sum   = cur_item.stored_sum;
    wire [31:0]  i_tick           = cur_item.field[0];
    wire [31:0]  i_duration       = cur_item.field[1];
    wire [31:0]  i_event_kind     = cur_item.field[2];
    wire [31:0]  i_channel        = cur_item.field[3];
    wire [31:0]  i_data_one       = cur_item.field[4];
    wire [31:0]  i_data_two       = cur_item.field[5];
    wire [31:0]  i_wide_value     = cur_item.field[6];
    wire [32:0]  i_layer_and_last = {cur_item.last, cur_item.field[7]};

    loop_record_validator #(
        .CAPACITY(RECORD_CAP)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_loop_length    (i_loop_length),
        .i_tempo_bpm      (i_tempo_bpm),
        .i_expected_sum   (i_expected_sum),
        .i_tick           (i_tick),
        .i_duration       (i_duration),
        .i_event_kind     (i_event_kind),
        .i_channel        (i_channel),
        .i_data_one       (i_data_one),
        .i_data_two       (i_data_two),
        .i_wide_value     (i_wide_value),
        .i_layer_and_last (i_layer_and_last),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_accepted       (o_accepted),
        .o_error_code     (o_error_code),
        .o_computed_sum   (o_computed_sum),
        .o_entry_total    (o_entry_total)
    );

    always #5 i_clk = ~i_clk;

    // hash one word, least significant byte first
    function automatic logic [31:0] fnv_word(input logic [31:0] h, input logic [31:0] w);
        logic [31:0] acc;
        int b;
        acc = h;
        for (b = 0; b < 4; b++) begin
            acc = acc ^ {24'd0, w[8*b +: 8]};
            acc = acc * FNV_MULT;
        end
        return acc;
    endfunction

    // every field random but the opcode, which is entry; ignored ones included
    function automatic t_loop_item rand_item();
        t_loop_item it;
        int f;
        it.op = OP_ENTRY;
        it.loop_len = $urandom();
        it.tempo = 16'($urandom_range(0, 16'hffff));
        it.stored_sum = $urandom();
        for (f = 0; f < 8; f++) it.field[f] = $urandom();
        it.last = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic clear_record();
        hash_acc = FNV_OFFSET;
        sum_want = '0;
        err_first = ERR_NONE;
        entry_cnt = '0;
        rec_open = 1'b0;
    endtask

    task automatic note_error(input logic [1:0] code);
        if (err_first == ERR_NONE) err_first = code;
    endtask

    // fold one transferred item into the record state, queue a verdict on close
    task automatic track_record_item(input t_loop_item it);
        t_verdict v;
        int f;
        if (it.op == OP_HEADER) begin
            clear_record();
            rec_open = 1'b1;
            hash_acc = fnv_word(hash_acc, it.loop_len);
            hash_acc = fnv_word(hash_acc, {16'd0, it.tempo});
            sum_want = it.stored_sum;
        end else if (rec_open) begin
            if (entry_cnt >= RECORD_CAP) note_error(ERR_CAPACITY);
            if (entry_cnt < RECORD_CAP + 1) entry_cnt = entry_cnt + 1'b1;
            for (f = 0; f < 8; f++) begin
                if (it.field[f] > FIELD_LIMIT[f]) note_error(ERR_RANGE);
                hash_acc = fnv_word(hash_acc, it.field[f]);
            end
        end
        if (it.last && rec_open) begin
            v.code = err_first;
            if (v.code == ERR_NONE && hash_acc != sum_want) v.code = ERR_CHECKSUM;
            v.accepted = (v.code == ERR_NONE);
            v.sum = hash_acc;
            v.total = entry_cnt;
            due_verdicts = {due_verdicts, v};
            clear_record();
        end
    endtask

    // queue a header and its entries; the stored sum is right in sum_ok_pct of cases
    task automatic add_record(input int n_ent, input t_fill fill, input int bad_pct,
                              input int bad_at, input int sum_ok_pct, input bit closed);
        t_loop_item hdr;
        t_loop_item ent;
        t_loop_item body[$];
        logic [31:0] h;
        int k;
        int f;
        int g;
        hdr = rand_item();
        hdr.op = OP_HEADER;
        hdr.last = closed && (n_ent == 0);
        if (fill == FILL_ONES) begin
            hdr.loop_len = '1;
            hdr.tempo = '1;
        end else if (fill == FILL_ZERO) begin
            hdr.loop_len = '0;
            hdr.tempo = '0;
        end
        h = fnv_word(fnv_word(FNV_OFFSET, hdr.loop_len), {16'd0, hdr.tempo});
        for (k = 0; k < n_ent; k++) begin
            ent = rand_item();
            ent.op = OP_ENTRY;
            ent.last = closed && (k == n_ent - 1);
            for (f = 0; f < 8; f++) begin
                case (fill)
                    FILL_LIMIT: ent.field[f] = FIELD_LIMIT[f];
                    FILL_ONES:  ent.field[f] = '1;
                    FILL_ZERO:  ent.field[f] = '0;
                    default:    ent.field[f] = $urandom_range(0, FIELD_LIMIT[f]);
                endcase
            end
            // one field pushed past its maximum
            if ($urandom_range(0, 99) < bad_pct || k == bad_at) begin
                g = $urandom_range(0, 7);
                case ($urandom_range(0, 2))
                    0:       ent.field[g] = FIELD_LIMIT[g] + 1;
                    1:       ent.field[g] = '1;
                    default: ent.field[g] = $urandom() | 32'h0010_0000;
                endcase
            end
            for (f = 0; f < 8; f++) h = fnv_word(h, ent.field[f]);
            body = {body, ent};
        end
        hdr.stored_sum = ($urandom_range(0, 99) < sum_ok_pct) ? h : $urandom();
        pending_items = {pending_items, hdr};
        for (k = 0; k < n_ent; k++) pending_items = {pending_items, body[k]};
        stim_count += n_ent + 1;
    endtask

    // driver: one item per transfer, gaps only between items
    always @(negedge i_clk) begin : drive_proc
        int phase;
        int idle_pct;
        int stall_pct;
        phase = (items_taken / PHASE_ITEMS) % 4;
        idle_pct = (phase == 1) ? 69 : (phase == 3) ? 27 : 0;
        stall_pct = (phase == 2) ? 69 : (phase == 3) ? 27 : 0;
        if (i_rst_n) begin
            if (!sending) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    cur_item = pending_items.pop_front();
                    i_valid <= 1'b1;
                    sending = 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // monitor: check each result transfer, then predict from each item transfer
    always @(posedge i_clk) begin : watch_proc
        t_verdict want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_verdicts.size() == 0) begin
                $display("%0t: result with no verdict pending: accepted %0d code %0d",
                         $time, o_accepted, o_error_code);
                $display("%0t: unexpected result: sum %h total %0d",
                         $time, o_computed_sum, o_entry_total);
                fail_count++;
            end else begin
                want = due_verdicts.pop_front();
                verdicts_checked++;
                code_seen[want.code]++;
                if (o_accepted !== want.accepted) begin
                    $display("%0t: accepted mismatch: expected %0d, actual %0d",
                             $time, want.accepted, o_accepted);
                    fail_count++;
                end
                if (o_error_code !== want.code) begin
                    $display("%0t: error code mismatch: expected %0d, actual %0d",
                             $time, want.code, o_error_code);
                    fail_count++;
                end
                if (o_computed_sum !== want.sum) begin
                    $display("%0t: computed sum mismatch: expected %h, actual %h",
                             $time, want.sum, o_computed_sum);
                    fail_count++;
                end
                if (o_entry_total !== want.total) begin
                    $display("%0t: entry total mismatch: expected %0d, actual %0d",
                             $time, want.total, o_entry_total);
                    fail_count++;
                end
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            track_record_item(cur_item);
            items_taken++;
            sending = 1'b0;
        end
    end

    // stimulus, reset and end of run
    initial begin
        t_loop_item stray;
        int pick;
        int long_done;
        bit left_open;

        // directed records
        add_record(0, FILL_RANDOM, 0, -1, 100, 1'b1);
        add_record(0, FILL_ONES, 0, -1, 0, 1'b1);
        stray = rand_item();
        stray.last = 1'b1;
        pending_items = {pending_items, stray};
        stim_count++;
        add_record(1, FILL_LIMIT, 0, -1, 100, 1'b1);
        add_record(1, FILL_ONES, 0, -1, 100, 1'b1);
        add_record(1, FILL_ZERO, 0, -1, 100, 1'b1);
        add_record(2, FILL_RANDOM, 0, -1, 100, 1'b0);
        add_record(2, FILL_RANDOM, 0, 1, 100, 1'b1);
        add_record(1, FILL_RANDOM, 0, -1, 100, 1'b0);
        add_record(0, FILL_RANDOM, 0, -1, 100, 1'b1);
        add_record(3, FILL_RANDOM, 0, -1, 0, 1'b1);

        // random records, with three long ones around the capacity limit
        long_done = 0;
        left_open = 1'b0;
        while (stim_count < ITEM_TARGET) begin
            if (long_done < 3 && stim_count > 250 + 400 * long_done) begin
                case (long_done)
                    0:       add_record(RECORD_CAP, FILL_RANDOM, 0, -1, 100, 1'b1);
                    1:       add_record(RECORD_CAP + 2, FILL_RANDOM, 0, RECORD_CAP + 1, 100,
                                        1'b1);
                    default: add_record(RECORD_CAP + 1, FILL_RANDOM, 0, 100, 100, 1'b1);
                endcase
                long_done++;
                left_open = 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 6 && !left_open) begin
                    // entry with no record open
                    pending_items = {pending_items, rand_item()};
                    stim_count++;
                end else if (pick < 16) begin
                    add_record($urandom_range(0, 4), FILL_RANDOM, 10, -1, 70, 1'b0);
                    left_open = 1'b1;
                end else begin
                    add_record($urandom_range(0, 12), FILL_RANDOM, 6, -1, 70, 1'b1);
                    left_open = 1'b0;
                end
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || sending) @(posedge i_clk);
        while (due_verdicts.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d items transferred, %0d verdicts checked", items_taken, verdicts_checked);
        $display("verdicts: ok %0d, range %0d, capacity %0d, checksum %0d",
                 code_seen[ERR_NONE], code_seen[ERR_RANGE], code_seen[ERR_CAPACITY],
                 code_seen[ERR_CHECKSUM]);
        if (fail_count == 0) begin
            $display("loop_record_validator test passed");
        end else begin
            $display("loop_record_validator test failed");
        end
        $finish;
    end

    // hang guard
    initial begin
        #10_000_000;
        $display("loop_record_validator test failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/lrv_pkg.sv
hw/rtl/loop_record_validator.sv
tb/loop_record_validator_test.sv
